@@ rtl/gcp_pkg.sv @@
// Shared types and constants of the grid curvature penalty block.
`timescale 1ns / 1ps
`default_nettype none
package gcp_pkg;

  localparam int AREA_W    = 32;
  localparam int INVPI_W   = 31;
  localparam int Q_W       = 47;
  localparam int RAD_W     = 24;
  localparam int DIF_W     = RAD_W + 1;
  localparam int D2_W      = RAD_W + 2;
  localparam int SQ_W      = 2 * D2_W - 16;
  localparam int SUM_W     = 56;
  localparam int OUT_W     = 64;
  localparam int WGT_W     = 8;
  localparam int GW_W      = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int DEF_MAX_WIDTH = 256;

  // round(2^32 / pi)
  localparam logic [INVPI_W-1:0] INV_PI_Q32 = 31'd1367130551;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

  typedef struct packed {
    logic             last;
    logic             valid;
    logic [RAD_W-1:0] radius;
  } gcp_item_t;

  typedef struct packed {
    logic             enable;
    logic [WGT_W-1:0] weight;
    logic [GW_W-1:0]  width;
  } gcp_cfg_t;

endpackage
`default_nettype wire

@@ rtl/gcp_front.sv @@
// Front end: takes a cell beat, scales the area by 1/pi and takes the square root.
`timescale 1ns / 1ps
`default_nettype none
module gcp_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [gcp_pkg::AREA_W-1:0] in_area,
  input  wire logic                       in_valid_flag,
  input  wire logic                       in_last,
  output logic                            push,
  output gcp_pkg::gcp_item_t              push_item,
  input  wire logic                       q_full
);
  import gcp_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SQRT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [AREA_W-1:0]   area_r;
  logic                vflag_r, last_r;
  logic [Q_W-1:0]      q_r;
  logic [RAD_W-1:0]    root_r, root_nxt;
  logic [4:0]          bit_r;
  logic [RAD_W-1:0]    cand;
  logic [2*RAD_W-1:0]  cand_sq;
  logic [AREA_W+INVPI_W-1:0] prod;

  assign in_tready = (state_r == F_IDLE) && !hold;
  assign prod      = (AREA_W+INVPI_W)'(area_r) * (AREA_W+INVPI_W)'(INV_PI_Q32);
  assign cand      = root_r | (RAD_W'(1) << bit_r);
  assign cand_sq   = (2*RAD_W)'(cand) * (2*RAD_W)'(cand);

  always_comb begin
    state_nxt = state_r;
    root_nxt  = root_r;
    case (state_r)
      F_IDLE: if (in_tvalid && in_tready) state_nxt = F_MUL;
      F_MUL: begin
        state_nxt = F_SQRT;
        root_nxt  = '0;
      end
      F_SQRT: begin
        if (cand_sq <= (2*RAD_W)'(q_r)) root_nxt = cand;
        if (bit_r == 5'd0) state_nxt = F_PUSH;
      end
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    root_r <= root_nxt;
    if (state_r == F_IDLE && in_tvalid && in_tready) begin
      area_r  <= in_area;
      vflag_r <= in_valid_flag;
      last_r  <= in_last;
    end
    if (state_r == F_MUL) begin
      q_r    <= prod[16 +: Q_W];
      bit_r  <= 5'(RAD_W - 1);
    end else if (state_r == F_SQRT) begin
      bit_r <= bit_r - 5'd1;
    end
  end

  assign push             = (state_r == F_PUSH) && !q_full;
  assign push_item.last   = last_r;
  assign push_item.valid  = vflag_r;
  assign push_item.radius = root_r;

endmodule
`default_nettype wire

@@ rtl/gcp_queue.sv @@
// Two-entry queue between the front end and the accumulating back end.
`timescale 1ns / 1ps
`default_nettype none
module gcp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gcp_pkg::gcp_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output gcp_pkg::gcp_item_t      pop_item,
  output logic                    not_empty
);
  import gcp_pkg::*;

  gcp_item_t  ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) ent_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

@@ rtl/gcp_back.sv @@
// Back end: row and column second differences, saturating sum, weighted result.
`timescale 1ns / 1ps
`default_nettype none
module gcp_back #(
  parameter int MAX_WIDTH = gcp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gcp_pkg::gcp_cfg_t         cfg,
  input  wire logic                      q_not_empty,
  input  wire gcp_pkg::gcp_item_t        q_item,
  output logic                           pop,
  output logic                           clr_busy,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [gcp_pkg::OUT_W-1:0]      out_tdata
);
  import gcp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > GW_W) ? CW + 1 : GW_W;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_CALC = 3'd2;
  localparam logic [2:0] B_SQ   = 3'd3;
  localparam logic [2:0] B_ACC1 = 3'd4;
  localparam logic [2:0] B_ACC2 = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    clr_r;
  logic [CW-1:0]    col_r;
  logic [1:0]       row_r;
  logic [RAD_W-1:0] pr0_r, pr1_r;
  logic             pv0_r, pv1_r;
  logic [SUM_W-1:0] sum_r;
  gcp_item_t        cur_r;

  logic [DIF_W-1:0] line_one [MAX_WIDTH];
  logic [DIF_W-1:0] line_two [MAX_WIDTH];
  logic [DIF_W-1:0] l1_q, l2_q;

  logic signed [D2_W-1:0]   d2h_r, d2v_r;
  logic                     h_en_r, v_en_r;
  logic [SQ_W-1:0]          sqh_r, sqv_r;
  logic signed [2*D2_W-1:0] ph, pv;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic [WW-1:0] w_eff, col_plus;
  logic          wrap;
  logic signed [DIF_W-1:0] dx_prev, dx_cur, dy;
  logic signed [D2_W-1:0]  d2h, d2v;
  logic          mem_we, out_load;
  logic [CW-1:0] mem_addr;
  logic [DIF_W-1:0] wd_one, wd_two;
  logic [OUT_W-1:0] prod;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                              input logic [SQ_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  always_comb begin
    if (cfg.width == '0) w_eff = WW'(1);
    else if (WW'(cfg.width) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg.width);
  end
  assign col_plus = WW'(col_r) + WW'(1);
  assign wrap     = col_plus >= w_eff;

  always_comb begin
    dx_prev = (pv0_r && pv1_r) ? $signed({1'b0, pr0_r}) - $signed({1'b0, pr1_r}) : '0;
    dx_cur  = (cur_r.valid && pv0_r) ?
              $signed({1'b0, cur_r.radius}) - $signed({1'b0, pr0_r}) : '0;
    d2h     = D2_W'(dx_cur) - D2_W'(dx_prev);
    dy      = (row_r != 2'd0 && cur_r.valid && l1_q[RAD_W]) ?
              $signed({1'b0, cur_r.radius}) - $signed({1'b0, l1_q[RAD_W-1:0]}) : '0;
    d2v     = D2_W'(dy) - D2_W'($signed(l2_q));
  end

  assign ph   = d2h_r * d2h_r;
  assign pv   = d2v_r * d2v_r;
  assign prod = cfg.enable ? (OUT_W'(sum_r) * OUT_W'(cfg.weight)) : '0;

  assign pop      = (state_r == B_IDLE) && q_not_empty;
  assign clr_busy = (state_r == B_CLR);
  assign out_load = (state_r == B_OUT) && (!out_valid_r || out_tready);
  assign mem_we   = clr_busy || (state_r == B_CALC);
  assign mem_addr = clr_busy ? clr_r : col_r;
  assign wd_one   = clr_busy ? '0 : {cur_r.valid, cur_r.radius};
  assign wd_two   = clr_busy ? '0 : DIF_W'(dy);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLR:  if (clr_r == CW'(MAX_WIDTH - 1)) state_nxt = B_IDLE;
      B_IDLE: if (q_not_empty) state_nxt = B_CALC;
      B_CALC: state_nxt = B_SQ;
      B_SQ:   state_nxt = B_ACC1;
      B_ACC1: state_nxt = B_ACC2;
      B_ACC2: state_nxt = cur_r.last ? B_OUT : B_IDLE;
      B_OUT:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_one[mem_addr] <= wd_one;
      line_two[mem_addr] <= wd_two;
    end
    if (pop) begin
      l1_q <= line_one[col_r];
      l2_q <= line_two[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= 2'd0;
      pv0_r       <= 1'b0;
      pv1_r       <= 1'b0;
      pr0_r       <= '0;
      pr1_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy) clr_r <= clr_r + CW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        B_CALC: begin
          if (wrap) begin
            col_r <= '0;
            pv0_r <= 1'b0;
            pv1_r <= 1'b0;
            pr0_r <= '0;
            pr1_r <= '0;
            if (row_r != 2'd2) row_r <= row_r + 2'd1;
          end else begin
            col_r <= col_r + CW'(1);
            pv1_r <= pv0_r;
            pr1_r <= pr0_r;
            pv0_r <= cur_r.valid;
            pr0_r <= cur_r.radius;
          end
        end
        B_ACC1: sum_r <= sat_add(sum_r, sqh_r);
        B_ACC2: sum_r <= sat_add(sum_r, sqv_r);
        B_OUT: begin
          if (out_load) begin
            sum_r       <= '0;
            col_r       <= '0;
            row_r       <= 2'd0;
            pv0_r       <= 1'b0;
            pv1_r       <= 1'b0;
            pr0_r       <= '0;
            pr1_r       <= '0;
          end
        end
        default: ;
      endcase
    end
    if (pop) cur_r <= q_item;
    if (state_r == B_CALC) begin
      d2h_r  <= d2h;
      d2v_r  <= d2v;
      h_en_r <= col_r >= CW'(2);
      v_en_r <= row_r == 2'd2;
    end
    if (state_r == B_SQ) begin
      sqh_r <= h_en_r ? ph[2*D2_W-1:16] : '0;
      sqv_r <= v_en_r ? pv[2*D2_W-1:16] : '0;
    end
    if (out_load) out_data_r <= prod;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(col_r) < WW'(MAX_WIDTH)))
    else $error("column counter out of range");
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (sum_r == '0 && col_r == '0 && row_r == 2'd0))
    else $error("grid state not cleared after result");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !pop && !out_valid_r)
    else $error("item taken during line buffer clear");
  a_row_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == 2'd2) |=> (row_r == 2'd2 || $past(out_load)))
    else $error("row count left saturation without a result");

endmodule
`default_nettype wire

@@ rtl/grid_curvature_penalty.sv @@
// Top level of the grid curvature penalty: configuration registers and unit wiring.
`timescale 1ns / 1ps
`default_nettype none
// Cells stream in raster order; the front end takes one cell at a time through the
// accept, the 1/pi multiply, the bit-per-cycle square root (24 steps) and the queue
// push (held while the queue is full); the back end's cell work overlaps the next root.
// A result beat appears only after a cell with tlast set and carries weight times
// the saturated sum of squared second differences (zero when disabled). After
// reset the line buffers are cleared, all MAX_WIDTH entries, during which no cell
// is taken; configuration writes are accepted at any time.
module grid_curvature_penalty #(
  parameter int MAX_WIDTH = gcp_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gcp_pkg::AREA_W-1:0]    in_tdata,   // [31:0] cell_area
  input  wire logic                          in_tuser,   // [0] cell_valid
  input  wire logic                          in_tlast,   // last_cell
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [gcp_pkg::OUT_W-1:0]          out_tdata,  // [63:0] penalty_scaled
  input  wire logic                          cfg_we,
  input  wire logic [gcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcp_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gcp_pkg::*;

  gcp_cfg_t  cfg_r;
  gcp_item_t push_item, pop_item;
  logic      push, q_full, pop, q_not_empty, clr_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.weight <= '0;
      cfg_r.width  <= GW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: cfg_r.enable <= cfg_data[0];
        CFG_WEIGHT: cfg_r.weight <= cfg_data[WGT_W-1:0];
        CFG_WIDTH:  cfg_r.width  <= cfg_data[GW_W-1:0];
        default: ;
      endcase
    end
  end

  gcp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (clr_busy),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_area      (in_tdata),
    .in_valid_flag(in_tuser),
    .in_last      (in_tlast),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  gcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_not_empty)
  );

  gcp_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .pop         (pop),
    .clr_busy    (clr_busy),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

@@ dv/gcp_checker.sv @@
// Checker for the grid curvature penalty: watches all ports, predicts and compares.
`timescale 1ns / 1ps
module gcp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [gcp_pkg::AREA_W-1:0]    in_tdata,
  input  logic                          in_tuser,
  input  logic                          in_tlast,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [gcp_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [gcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcp_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            fails,
  output int                            pending
);
  import gcp_pkg::*;

  localparam int LINE_D = DEF_MAX_WIDTH;
  localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 64'd1;

  logic             enable_q;
  logic [WGT_W-1:0] weight_q;
  logic [GW_W-1:0]  width_q;

  logic [RAD_W-1:0] hist_radius [2];
  logic             hist_valid  [2];
  logic [RAD_W:0]   above_cell  [LINE_D];  // {valid, radius} of the row above
  longint           above_dy    [LINE_D];  // vertical first difference into row above
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  longint unsigned  sq_sum;

  logic [OUT_W-1:0] penalty_q [$];

  assign pending = penalty_q.size();

  function automatic logic [RAD_W-1:0] area_radius(logic [AREA_W-1:0] area);
    longint unsigned q, res, probe;
    q = (64'(area) * 64'(INV_PI_Q32)) >> 16;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > q) probe >>= 2;
    while (probe != 0) begin
      if (q >= res + probe) begin
        q -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res[RAD_W-1:0];
  endfunction

  task automatic accumulate(longint d2);
    longint unsigned mag, sq;
    mag = (d2 < 0) ? -d2 : d2;
    sq = (mag * mag) >> 16;
    if (sq_sum > SUM_SAT - sq) sq_sum = SUM_SAT;
    else sq_sum += sq;
  endtask

  task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fails++;
  endtask

  task automatic predict_cell(logic [AREA_W-1:0] area, logic cv, logic last);
    logic [RAD_W-1:0] r;
    int unsigned w, col;
    longint dx_prev, dx_cur, dy;
    r = area_radius(area);
    w = (width_q == 0) ? 1 : (width_q > LINE_D) ? LINE_D : width_q;
    col = (col_cnt >= LINE_D) ? LINE_D - 1 : col_cnt;
    dy = 0;
    if (col >= 2) begin
      dx_prev = (hist_valid[0] && hist_valid[1]) ?
                longint'(hist_radius[0]) - longint'(hist_radius[1]) : 0;
      dx_cur = (cv && hist_valid[0]) ? longint'(r) - longint'(hist_radius[0]) : 0;
      accumulate(dx_cur - dx_prev);
    end
    hist_radius[1] = hist_radius[0];
    hist_valid[1] = hist_valid[0];
    hist_radius[0] = r;
    hist_valid[0] = cv;
    if (row_cnt >= 1) begin
      if (cv && above_cell[col][RAD_W])
        dy = longint'(r) - longint'(above_cell[col][RAD_W-1:0]);
      if (row_cnt >= 2) accumulate(dy - above_dy[col]);
    end
    above_dy[col] = dy;
    above_cell[col] = {cv, r};
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      hist_valid[0] = 0;
      hist_valid[1] = 0;
      hist_radius[0] = 0;
      hist_radius[1] = 0;
      if (row_cnt < 65535) row_cnt++;
    end else begin
      col_cnt++;
    end
    if (last) begin
      penalty_q.push_back(enable_q ? 64'(weight_q) * sq_sum : 64'd0);
      col_cnt = 0;
      row_cnt = 0;
      sq_sum = 0;
      hist_valid[0] = 0;
      hist_valid[1] = 0;
      hist_radius[0] = 0;
      hist_radius[1] = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      enable_q <= 1'b0;
      weight_q <= '0;
      width_q <= GW_W'(1);
      col_cnt = 0;
      row_cnt = 0;
      sq_sum = 0;
      for (int i = 0; i < 2; i++) begin
        hist_radius[i] = '0;
        hist_valid[i] = 1'b0;
      end
      for (int i = 0; i < LINE_D; i++) begin
        above_cell[i] = '0;
        above_dy[i] = 0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: enable_q <= cfg_data[0];
          CFG_WEIGHT: weight_q <= cfg_data[WGT_W-1:0];
          CFG_WIDTH:  width_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_cell(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (penalty_q.size() == 0) report("unexpected beat", out_tdata, '0);
        else begin
          logic [OUT_W-1:0] want;
          want = penalty_q.pop_front();
          if (out_tdata !== want) report("penalty_scaled", out_tdata, want);
        end
      end
    end
  end

  initial fails = 0;
endmodule

@@ dv/tb_grid_curvature_penalty.sv @@
// Testbench top: clock, reset, stimulus and verdict for the grid curvature penalty.
`timescale 1ns / 1ps
module tb_grid_curvature_penalty;
  import gcp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [AREA_W-1:0]    in_tdata = '0;   // [31:0] cell_area
  logic                 in_tuser = 1'b0; // [0] cell_valid
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;       // [63:0] penalty_scaled
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLE;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   fails, pending;
  int                   burst_left = 0;
  int                   sent = 0;
  logic [AREA_W-1:0]    smooth_base = 32'h0001_0000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_curvature_penalty dut (.*);

  gcp_checker chk (.*);

  // receiver: stretches of always-ready, random stalls, and long stalls
  int stall_mode = 0, stall_len = 0;
  always @(posedge clk) begin
    if (stall_len == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_len <= $urandom_range(1, 60);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      default: out_tready <= (stall_len % 20 == 0);
    endcase
  end

  task automatic send_cell(logic [AREA_W-1:0] area, logic cv, logic last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= area;
    in_tuser <= cv;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent++;
  endtask

  function automatic logic [AREA_W-1:0] pick_area();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4: return $urandom_range(0, 255);
      default: begin
        smooth_base = smooth_base + $urandom_range(0, 8191) - 4096;
        return smooth_base;
      end
    endcase
  endfunction

  // wait for the block to drain, then rewrite all three registers
  task automatic reconfigure(logic en, logic [WGT_W-1:0] wt, logic [GW_W-1:0] wd);
    in_tvalid <= 1'b0;
    // let the checker see the last accepted beat before looking at pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data <= CFG_DAT_W'(en);
    @(posedge clk);
    cfg_index <= CFG_WEIGHT;
    cfg_data <= CFG_DAT_W'(wt);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data <= wd;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_grid(int cells, int valid_pct);
    for (int i = 0; i < cells; i++)
      send_cell(pick_area(), $urandom_range(0, 99) < valid_pct, i == cells - 1);
  endtask

  initial begin
    int w, rows, cells;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes on a 3x3 grid: alternating zero and full-scale areas
    reconfigure(1'b1, 8'd255, 9'd3);
    for (int i = 0; i < 9; i++) send_cell((i % 2) ? '1 : '0, 1'b1, i == 8);
    // masked cells break the differences
    for (int i = 0; i < 9; i++) send_cell('1, i != 4, i == 8);
    // single column: vertical terms only
    reconfigure(1'b1, 8'd1, 9'd1);
    send_cell('1, 1'b1, 1'b0);
    send_cell('0, 1'b1, 1'b0);
    send_cell('1, 1'b1, 1'b0);
    send_cell(32'h8000_0000, 1'b1, 1'b1);
    // disabled, then zero weight: sum still accumulates but reads zero
    reconfigure(1'b0, 8'd200, 9'd2);
    for (int i = 0; i < 6; i++) send_cell($urandom, 1'b1, i == 5);
    // width zero acts as one; a lone last cell
    reconfigure(1'b1, 8'd0, 9'd0);
    send_cell($urandom, 1'b1, 1'b1);

    // oversized width clamps to the line length
    reconfigure(1'b1, 8'd37, 9'd300);
    send_grid(12, 90);
    reconfigure(1'b1, 8'd255, 9'd256);
    send_grid(256 + 24, 85);

    while (sent < 1150) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      reconfigure($urandom_range(0, 5) != 0, WGT_W'($urandom), GW_W'(w));
      repeat ($urandom_range(1, 3)) begin
        rows = $urandom_range(1, 6);
        cells = rows * w;
        if ($urandom_range(0, 3) == 0) cells = cells - $urandom_range(0, w - 1);
        send_grid(cells, ($urandom_range(0, 3) == 0) ? 50 : 95);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
